// ----- sv/ohab_pkg.sv -----
// ----------------------------------------------------------------------------
// ohab_pkg - shared types and constants of the OHLCV bar aggregator
// Field widths, the volume saturation limit, register reset value and the
// status record of the remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ohab_pkg;

  localparam int TIME_W   = 32;
  localparam int PRICE_W  = 32;
  localparam int TVOL_W   = 32;
  localparam int VOL_W    = 48;
  localparam int IVL_W    = 17;
  localparam int DIV_CNT_W = 5;

  localparam logic [VOL_W-1:0]     VOL_MAX   = {VOL_W{1'b1}};
  localparam logic [IVL_W-1:0]     IVL_RESET = 17'd60;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = {DIV_CNT_W{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- sv/ohab_if.sv -----
// ----------------------------------------------------------------------------
// ohab_if - channel interfaces of the OHLCV bar aggregator
// Tick input, bar output and interval register write channels, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface ohab_tick_if;
  logic                          valid;
  logic                          ready;
  logic [ohab_pkg::TIME_W-1:0]   time_seconds;
  logic [ohab_pkg::PRICE_W-1:0]  price;
  logic [ohab_pkg::TVOL_W-1:0]   trade_volume;

  modport source (output valid, time_seconds, price, trade_volume, input ready);
  modport sink   (input valid, time_seconds, price, trade_volume, output ready);
endinterface

interface ohab_bar_if;
  logic                          valid;
  logic                          ready;
  logic [ohab_pkg::TIME_W-1:0]   bar_start;
  logic [ohab_pkg::PRICE_W-1:0]  open_price;
  logic [ohab_pkg::PRICE_W-1:0]  high_price;
  logic [ohab_pkg::PRICE_W-1:0]  low_price;
  logic [ohab_pkg::PRICE_W-1:0]  close_price;
  logic [ohab_pkg::VOL_W-1:0]    total_volume;

  modport source (output valid, bar_start, open_price, high_price, low_price,
                  close_price, total_volume, input ready);
  modport sink   (input valid, bar_start, open_price, high_price, low_price,
                  close_price, total_volume, output ready);
endinterface

interface ohab_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ohab_pkg::IVL_W-1:0]    bar_secs;

  modport source (output valid, bar_secs, input ready);
  modport sink   (input valid, bar_secs, output ready);
endinterface

`default_nettype wire

// ----- sv/ohab_div.sv -----
// ----------------------------------------------------------------------------
// ohab_div - iterative remainder unit
// Restoring division of a 32-bit time by the 17-bit interval, one quotient
// bit per cycle; returns the remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module ohab_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [ohab_pkg::TIME_W-1:0]    dividend,
  input  wire logic [ohab_pkg::IVL_W-1:0]     divisor,
  output ohab_pkg::div_stat_t                 stat,
  output logic      [ohab_pkg::IVL_W-1:0]     remainder
);

  logic                             busy;
  logic                             done;
  logic [ohab_pkg::DIV_CNT_W-1:0]   cnt;
  logic [ohab_pkg::TIME_W-1:0]      quo;
  logic [ohab_pkg::IVL_W-1:0]       rem;
  logic [ohab_pkg::IVL_W-1:0]       dvs;

  logic [ohab_pkg::IVL_W:0]         trial;
  logic [ohab_pkg::IVL_W:0]         diff;
  logic                             fit;
  logic [ohab_pkg::IVL_W-1:0]       rem_next;

  // bring down the next dividend bit and subtract where it fits
  always_comb begin
    trial    = {rem, quo[ohab_pkg::TIME_W-1]};
    diff     = trial - {1'b0, dvs};
    fit      = (trial >= {1'b0, dvs});
    rem_next = fit ? diff[ohab_pkg::IVL_W-1:0] : trial[ohab_pkg::IVL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ohab_pkg::DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[ohab_pkg::TIME_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("remainder not below divisor");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("remainder unit restarted while busy");

endmodule

`default_nettype wire

// ----- sv/ohlcv_bar_aggregator.sv -----
// ----------------------------------------------------------------------------
// ohlcv_bar_aggregator - time bars from a stream of trade ticks
// Groups ticks into open/high/low/close/volume bars of a programmable length.
// ----------------------------------------------------------------------------
// Usage:
//   tick  : sink of tick requests (time in seconds, price, volume).
//   bar   : source of completed bars; one request per bar that closes.
//   cfg   : write of the bar interval in seconds (0 acts as 1); always
//           ready, to be written only while the block is idle.
// A tick that falls inside the open bar is accepted, then updates the bar.
// A tick that opens a bar (the first one, or one past the bar end) is
// accepted, passes the end test, runs through the restoring divider to
// round its time down to the interval, and then loads the new bar.
// tick.ready is high only while the sequencer is idle.
// A completed bar sits in an output register, so the next tick is taken
// while it waits; if another bar closes before it is taken, the sequencer
// holds in the end test until bar.ready.
// Reset clears the sequencer, drops any open bar and any waiting bar, and
// sets the interval to 60 seconds. The last bar is never flushed.
// ----------------------------------------------------------------------------
`default_nettype none

module ohlcv_bar_aggregator (
  input  wire logic  clk,
  input  wire logic  rst,
  ohab_tick_if.sink  tick,
  ohab_bar_if.source bar,
  ohab_cfg_if.sink   cfg
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]                       state;
  logic [ohab_pkg::IVL_W-1:0]       ivl;
  logic                             bar_open;
  logic                             out_valid;

  logic [ohab_pkg::TIME_W-1:0]      t_r;
  logic [ohab_pkg::PRICE_W-1:0]     p_r;
  logic [ohab_pkg::TVOL_W-1:0]      v_r;

  logic [ohab_pkg::TIME_W-1:0]      cur_start;
  logic [ohab_pkg::PRICE_W-1:0]     cur_open;
  logic [ohab_pkg::PRICE_W-1:0]     cur_high;
  logic [ohab_pkg::PRICE_W-1:0]     cur_low;
  logic [ohab_pkg::PRICE_W-1:0]     cur_close;
  logic [ohab_pkg::VOL_W-1:0]       cur_volume;

  logic [ohab_pkg::TIME_W-1:0]      out_start;
  logic [ohab_pkg::PRICE_W-1:0]     out_open;
  logic [ohab_pkg::PRICE_W-1:0]     out_high;
  logic [ohab_pkg::PRICE_W-1:0]     out_low;
  logic [ohab_pkg::PRICE_W-1:0]     out_close;
  logic [ohab_pkg::VOL_W-1:0]       out_volume;

  logic [ohab_pkg::IVL_W-1:0]       eff_ivl;
  logic [ohab_pkg::TIME_W:0]        bar_end;
  logic                             past_end;
  logic                             out_free;
  logic                             tick_acc;
  logic                             div_start;
  logic                             emit;
  logic                             upd;
  logic [ohab_pkg::VOL_W:0]         vol_sum;
  logic [ohab_pkg::VOL_W-1:0]       vol_next;

  ohab_pkg::div_stat_t              div_stat;
  logic [ohab_pkg::IVL_W-1:0]       div_rem;

  assign eff_ivl  = (ivl == '0) ? {{(ohab_pkg::IVL_W-1){1'b0}}, 1'b1} : ivl;
  // bar end in 33 bits so it never wraps
  assign bar_end  = {1'b0, cur_start}
                  + {{(ohab_pkg::TIME_W+1-ohab_pkg::IVL_W){1'b0}}, eff_ivl};
  assign past_end = ({1'b0, t_r} >= bar_end);
  assign out_free = !out_valid || bar.ready;
  assign tick_acc = tick.valid && tick.ready;

  assign emit      = (state == S_EVAL) && bar_open && past_end && out_free;
  assign div_start = (state == S_EVAL) && (!bar_open || (past_end && out_free));
  assign upd       = (state == S_EVAL) && bar_open && !past_end;

  assign vol_sum  = {1'b0, cur_volume}
                  + {{(ohab_pkg::VOL_W+1-ohab_pkg::TVOL_W){1'b0}}, v_r};
  assign vol_next = vol_sum[ohab_pkg::VOL_W] ? ohab_pkg::VOL_MAX
                                             : vol_sum[ohab_pkg::VOL_W-1:0];

  ohab_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (t_r),
    .divisor   (eff_ivl),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ivl       <= ohab_pkg::IVL_RESET;
      bar_open  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        ivl <= cfg.bar_secs;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (bar.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick_acc) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (div_start) begin
            state <= S_DIV;
          end else if (upd) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            bar_open <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      t_r <= tick.time_seconds;
      p_r <= tick.price;
      v_r <= tick.trade_volume;
    end
    if (emit) begin
      out_start  <= cur_start;
      out_open   <= cur_open;
      out_high   <= cur_high;
      out_low    <= cur_low;
      out_close  <= cur_close;
      out_volume <= cur_volume;
    end
    if (upd) begin
      if (p_r > cur_high) begin
        cur_high <= p_r;
      end
      if (p_r < cur_low) begin
        cur_low <= p_r;
      end
      cur_close  <= p_r;
      cur_volume <= vol_next;
    end else if ((state == S_DIV) && div_stat.done) begin
      // open a new bar from the held tick
      cur_start  <= t_r - {{(ohab_pkg::TIME_W-ohab_pkg::IVL_W){1'b0}}, div_rem};
      cur_open   <= p_r;
      cur_high   <= p_r;
      cur_low    <= p_r;
      cur_close  <= p_r;
      cur_volume <= {{(ohab_pkg::VOL_W-ohab_pkg::TVOL_W){1'b0}}, v_r};
    end
  end

  assign tick.ready       = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign bar.valid        = out_valid;
  assign bar.bar_start    = out_start;
  assign bar.open_price   = out_open;
  assign bar.high_price   = out_high;
  assign bar.low_price    = out_low;
  assign bar.close_price  = out_close;
  assign bar.total_volume = out_volume;

  a_low_not_above_high: assert property (@(posedge clk) disable iff (rst)
    bar_open |-> (cur_low <= cur_high))
    else $error("bar low above bar high");

  a_div_only_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside its state");

  a_stalled_bar_blocks_emit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !bar.ready) |-> !emit)
    else $error("bar overwritten while waiting");

endmodule

`default_nettype wire
